// ----- hdl/llds_pkg.sv -----
// Package for the local luma deviation unit: field widths, register codes,
// default parameter values and request type codes.
// No dependencies.
package llds_pkg;

   localparam int SAMPLE_W    = 15;
   localparam int DEV_W       = 16;
   localparam int WIDTH_REG_W = 11;
   localparam int HEIGHT_W    = 16;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   localparam int DEF_MAX_WIDTH     = 1024;
   localparam int DEF_WINDOW_RADIUS = 2;
   localparam int DEF_ROOT_W        = 21;

   localparam int DEV_MAX = 65535;

   localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET = 16'd1;

   // Register index, taken from the word address bit of the CSR port.
   localparam logic CSR_IDX_WIDTH  = 1'b0;
   localparam logic CSR_IDX_HEIGHT = 1'b1;

   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_FLUSH  = 1'b1;

endpackage

// ----- hdl/llds_req_if.sv -----
// Request channel of the local luma deviation unit: valid/ready plus sample payload.
// Depends on llds_pkg.
interface llds_req_if import llds_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                req_type;
   logic [SAMPLE_W-1:0] lum_sample;

   modport source (output valid, output req_type, output lum_sample, input ready);
   modport sink   (input valid, input req_type, input lum_sample, output ready);
endinterface

// ----- hdl/llds_rsp_if.sv -----
// Response channel of the local luma deviation unit: valid/ready plus result payload.
// Depends on llds_pkg.
interface llds_rsp_if import llds_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [DEV_W-1:0] deviation;
   logic             last_of_frame;

   modport source (output valid, output deviation, output last_of_frame, input ready);
   modport sink   (input valid, input deviation, input last_of_frame, output ready);
endinterface

// ----- hdl/llds_root_cell.sv -----
// One cell of the integer square root chain: settles one result bit per cell.
// Depends on llds_pkg for its default width.
module llds_root_cell
   import llds_pkg::*;
#(
   parameter int S_W = DEF_ROOT_W
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             valid_in,
   input  logic [2*S_W-1:0] rad_in,
   input  logic [S_W+1:0]   rem_in,
   input  logic [S_W-1:0]   root_in,
   output logic             valid_out,
   output logic [2*S_W-1:0] rad_out,
   output logic [S_W+1:0]   rem_out,
   output logic [S_W-1:0]   root_out
);

   logic             valid_ff;
   logic [2*S_W-1:0] rad_ff, rad_in_next;
   logic [S_W+1:0]   rem_ff, rem_in_next;
   logic [S_W-1:0]   root_ff, root_in_next;
   logic [S_W+3:0]   rem_sh;
   logic [S_W+3:0]   trial;
   logic [S_W+3:0]   diff;
   logic             take;

   // Bring down the next two radicand bits and try the trial divisor 4*root + 1.
   always_comb begin
      rem_sh       = {rem_in, rad_in[2*S_W-1 -: 2]};
      trial        = {2'b00, root_in, 2'b01};
      diff         = rem_sh - trial;
      take         = (rem_sh >= trial);
      rem_in_next  = take ? diff[S_W+1:0] : rem_sh[S_W+1:0];
      root_in_next = {root_in[S_W-2:0], take};
      rad_in_next  = {rad_in[2*S_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in_next;
      rem_ff  <= rem_in_next;
      root_ff <= root_in_next;
   end

   assign valid_out = valid_ff;
   assign rad_out   = rad_ff;
   assign rem_out   = rem_ff;
   assign root_out  = root_ff;

endmodule

// ----- hdl/local_luma_deviation_5x5_unit.sv -----
// An accepted sample that completes a neighbourhood passes through the serial sample
// gather, the product and difference steps, the bit-serial divider and the root cell
// chain before its result is offered. Throughput: one transaction at a time; a
// transaction without a result frees the input after the step and decide states.
// Reset: synchronous, active high; registers return to width 1024, height 1 and
// position zero. The line store is not cleared.
module local_luma_deviation_5x5_unit
   import llds_pkg::*;
#(
   parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
   parameter int WINDOW_RADIUS = DEF_WINDOW_RADIUS
)
(
   input  logic                  clock,
   input  logic                  reset,
   llds_req_if.sink              req_chan,
   llds_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int WIN_SIDE   = 2 * WINDOW_RADIUS + 1;
   localparam int WIN_SIZE   = WIN_SIDE * WIN_SIDE;
   localparam int HIST_DEPTH = 2 * WINDOW_RADIUS * MAX_WIDTH + 2 * WINDOW_RADIUS + 8;
   localparam int ADDR_W     = $clog2(HIST_DEPTH);
   localparam int W_W        = $clog2(MAX_WIDTH + 1);
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int CMP_W      = (W_W > WIDTH_REG_W) ? W_W + 1 : WIDTH_REG_W + 1;
   localparam int IDX_W      = HEIGHT_W + W_W;
   localparam int N_W        = $clog2(WIN_SIZE + 1);
   localparam int SUM_W      = SAMPLE_W + N_W;
   localparam int SQ_W       = 2 * SAMPLE_W + N_W;
   localparam int T_W        = SQ_W + N_W;
   localparam int Q_W        = T_W + 2;
   localparam int S_W        = (Q_W + 1) / 2;
   localparam int OFF_W      = ADDR_W + 2;
   localparam int D_W        = $clog2(WINDOW_RADIUS + 1) + 1;
   localparam int G_W        = $clog2(WIN_SIZE + 2);
   localparam int DC_W       = $clog2(Q_W);
   localparam int RR_W       = HEIGHT_W + 2;
   localparam int CC_W       = W_W + 2;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_STEP   = 10'b0000000010,
      ST_DECIDE = 10'b0000000100,
      ST_GATHER = 10'b0000001000,
      ST_MUL    = 10'b0000010000,
      ST_TDIFF  = 10'b0000100000,
      ST_DIV    = 10'b0001000000,
      ST_ROOT   = 10'b0010000000,
      ST_WAIT   = 10'b0100000000,
      ST_PUSH   = 10'b1000000000
   } llds_state_type;

   // Control state
   llds_state_type         state_ff, state_in;
   logic [WIDTH_REG_W-1:0] width_reg_ff, width_reg_in;
   logic [HEIGHT_W-1:0]    height_reg_ff, height_reg_in;
   logic [HEIGHT_W-1:0]    in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [COL_W-1:0]       in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [IDX_W-1:0]       in_idx_ff, in_idx_in, out_idx_ff, out_idx_in;
   logic [ADDR_W-1:0]      in_addr_ff, in_addr_in, out_addr_ff, out_addr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rd_val_ff, rd_val_in, val2_ff, val2_in;
   logic [G_W-1:0]         g_cnt_ff, g_cnt_in;
   logic [DC_W-1:0]        div_cnt_ff, div_cnt_in;

   // Datapath
   logic [W_W-1:0]         w_ff, w_in;
   logic [HEIGHT_W-1:0]    h_ff, h_in;
   logic [IDX_W-1:0]       total_ff, total_in, lag_ff, lag_in;
   logic [ADDR_W-1:0]      rw_ff, rw_in;
   logic                   item_type_ff, item_type_in;
   logic [SAMPLE_W-1:0]    item_sample_ff, item_sample_in;
   logic [HEIGHT_W-1:0]    cen_row_ff, cen_row_in;
   logic [COL_W-1:0]       cen_col_ff, cen_col_in;
   logic [ADDR_W-1:0]      cen_addr_ff, cen_addr_in;
   logic                   cen_last_ff, cen_last_in;
   logic signed [D_W-1:0]  dr_ff, dr_in, dc_ff, dc_in;
   logic signed [OFF_W-1:0] row_off_ff, row_off_in;
   logic [SAMPLE_W-1:0]    rd_data_ff, data_d_ff, data_d_in;
   logic [2*SAMPLE_W-1:0]  sq_ff, sq_in;
   logic [N_W-1:0]         acc_n_ff, acc_n_in;
   logic [SUM_W-1:0]       acc_sum_ff, acc_sum_in;
   logic [SQ_W-1:0]        acc_sq_ff, acc_sq_in;
   logic [T_W-1:0]         p1_ff, p1_in, p2_ff, p2_in;
   logic [Q_W-1:0]         div_q_ff, div_q_in;
   logic [N_W-1:0]         div_rem_ff, div_rem_in;
   logic [DEV_W-1:0]       res_ff, res_in, rsp_dev_ff, rsp_dev_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [SAMPLE_W-1:0]    line_mem [HIST_DEPTH];

   // Combinational helpers
   logic                   csr_write;
   logic                   req_acc;
   logic [CMP_W-1:0]       wreg_ext;
   logic                   mem_we;
   logic                   issue;
   logic signed [OFF_W-1:0] nb_sum, nb_wrap;
   logic [ADDR_W-1:0]      rd_addr;
   logic signed [RR_W-1:0] nb_row;
   logic signed [CC_W-1:0] nb_col;
   logic                   nb_inside;
   logic [IDX_W:0]         have_ext, need_ext, total_ext;
   logic                   emit;
   logic                   is_last;
   logic [CMP_W-1:0]       col_next;
   logic [N_W:0]           rem_sh;
   logic                   rem_ge;
   logic [S_W:0]           r_wide;

   // Root chain taps
   logic [S_W:0]           cv;
   logic [2*S_W-1:0]       crad  [S_W];
   logic [S_W+1:0]         crem  [S_W];
   logic [S_W-1:0]         croot [S_W+1];

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign req_acc    = req_chan.valid && req_chan.ready;

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.deviation     = rsp_dev_ff;
   assign rsp_chan.last_of_frame = rsp_last_ff;

   always_comb begin
      if (csr_paddr[2] == CSR_IDX_HEIGHT) begin
         csr_prdata = CSR_DATA_W'(height_reg_ff);
      end else begin
         csr_prdata = CSR_DATA_W'(width_reg_ff);
      end
   end

   // Effective frame geometry, registered every cycle from the CSRs.
   always_comb begin
      wreg_ext = CMP_W'(width_reg_ff);
      if (wreg_ext == '0) begin
         w_in = W_W'(1);
      end else if (wreg_ext > CMP_W'(MAX_WIDTH)) begin
         w_in = W_W'(MAX_WIDTH);
      end else begin
         w_in = W_W'(wreg_ext);
      end
      h_in     = (height_reg_ff == '0) ? HEIGHT_W'(1) : height_reg_ff;
      total_in = IDX_W'(w_in) * IDX_W'(h_in);
      rw_in    = ADDR_W'(WINDOW_RADIUS * int'(w_in));
      lag_in   = IDX_W'(rw_in) + IDX_W'(WINDOW_RADIUS + 1);
   end

   // Neighbour address and border test for the current window position.
   always_comb begin
      issue   = (state_ff == ST_GATHER) && (g_cnt_ff < G_W'(WIN_SIZE));
      nb_sum  = $signed(OFF_W'(cen_addr_ff)) + row_off_ff + OFF_W'(dc_ff);
      if (nb_sum < 0) begin
         nb_wrap = nb_sum + OFF_W'(HIST_DEPTH);
      end else if (nb_sum >= OFF_W'(HIST_DEPTH)) begin
         nb_wrap = nb_sum - OFF_W'(HIST_DEPTH);
      end else begin
         nb_wrap = nb_sum;
      end
      rd_addr   = nb_wrap[ADDR_W-1:0];
      nb_row    = $signed(RR_W'(cen_row_ff)) + RR_W'(dr_ff);
      nb_col    = $signed(CC_W'(cen_col_ff)) + CC_W'(dc_ff);
      nb_inside = !nb_row[RR_W-1] && (nb_row[RR_W-2:0] < (RR_W-1)'(h_ff))
                  && !nb_col[CC_W-1] && (nb_col[CC_W-2:0] < (CC_W-1)'(w_ff));
   end

   always_comb begin
      total_ext = (IDX_W+1)'(total_ff);
      have_ext  = (IDX_W+1)'(in_idx_ff);
      need_ext  = (IDX_W+1)'(out_idx_ff) + (IDX_W+1)'(lag_ff);
      if (need_ext > total_ext) begin
         need_ext = total_ext;
      end
      emit     = (have_ext >= need_ext);
      is_last  = ((IDX_W+1)'(out_idx_ff) + (IDX_W+1)'(1)) >= total_ext;
      col_next = CMP_W'(in_col_ff) + CMP_W'(1);
      rem_sh   = {div_rem_ff, div_q_ff[Q_W-1]};
      rem_ge   = (rem_sh >= (N_W+1)'(acc_n_ff));
      r_wide   = ((S_W+1)'(croot[S_W]) + (S_W+1)'(1)) >> 1;
   end

   assign mem_we = (state_ff == ST_STEP) && (item_type_ff == REQ_SAMPLE) && (in_row_ff < h_ff);

   always_comb begin
      state_in       = state_ff;
      width_reg_in   = width_reg_ff;
      height_reg_in  = height_reg_ff;
      in_row_in      = in_row_ff;
      in_col_in      = in_col_ff;
      in_idx_in      = in_idx_ff;
      in_addr_in     = in_addr_ff;
      out_row_in     = out_row_ff;
      out_col_in     = out_col_ff;
      out_idx_in     = out_idx_ff;
      out_addr_in    = out_addr_ff;
      rsp_valid_in   = rsp_valid_ff;
      g_cnt_in       = g_cnt_ff;
      div_cnt_in     = div_cnt_ff;
      item_type_in   = item_type_ff;
      item_sample_in = item_sample_ff;
      cen_row_in     = cen_row_ff;
      cen_col_in     = cen_col_ff;
      cen_addr_in    = cen_addr_ff;
      cen_last_in    = cen_last_ff;
      dr_in          = dr_ff;
      dc_in          = dc_ff;
      row_off_in     = row_off_ff;
      acc_n_in       = acc_n_ff;
      acc_sum_in     = acc_sum_ff;
      acc_sq_in      = acc_sq_ff;
      p1_in          = p1_ff;
      p2_in          = p2_ff;
      div_q_in       = div_q_ff;
      div_rem_in     = div_rem_ff;
      res_in         = res_ff;
      rsp_dev_in     = rsp_dev_ff;
      rsp_last_in    = rsp_last_ff;
      rd_val_in      = issue && nb_inside;
      val2_in        = rd_val_ff;
      data_d_in      = rd_data_ff;
      sq_in          = (2*SAMPLE_W)'(rd_data_ff) * (2*SAMPLE_W)'(rd_data_ff);

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               item_type_in   = req_chan.req_type;
               item_sample_in = req_chan.lum_sample;
               state_in       = ST_STEP;
            end
         end
         ST_STEP: begin
            if (mem_we) begin
               in_idx_in  = in_idx_ff + IDX_W'(1);
               in_addr_in = (in_addr_ff == ADDR_W'(HIST_DEPTH - 1)) ? '0
                            : in_addr_ff + ADDR_W'(1);
               if (col_next >= CMP_W'(w_ff)) begin
                  in_col_in = '0;
                  in_row_in = in_row_ff + HEIGHT_W'(1);
               end else begin
                  in_col_in = COL_W'(col_next);
               end
            end
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (emit) begin
               cen_row_in  = out_row_ff;
               cen_col_in  = out_col_ff;
               cen_addr_in = out_addr_ff;
               cen_last_in = is_last;
               dr_in       = D_W'(-WINDOW_RADIUS);
               dc_in       = D_W'(-WINDOW_RADIUS);
               row_off_in  = -$signed(OFF_W'(rw_ff));
               g_cnt_in    = '0;
               acc_n_in    = '0;
               acc_sum_in  = '0;
               acc_sq_in   = '0;
               if (is_last) begin
                  // End of frame: every position counter starts again.
                  in_row_in   = '0;
                  in_col_in   = '0;
                  in_idx_in   = '0;
                  in_addr_in  = '0;
                  out_row_in  = '0;
                  out_col_in  = '0;
                  out_idx_in  = '0;
                  out_addr_in = '0;
               end else begin
                  out_idx_in  = out_idx_ff + IDX_W'(1);
                  out_addr_in = (out_addr_ff == ADDR_W'(HIST_DEPTH - 1)) ? '0
                                : out_addr_ff + ADDR_W'(1);
                  if ((CMP_W'(out_col_ff) + CMP_W'(1)) >= CMP_W'(w_ff)) begin
                     out_col_in = '0;
                     out_row_in = out_row_ff + HEIGHT_W'(1);
                  end else begin
                     out_col_in = out_col_ff + COL_W'(1);
                  end
               end
               state_in = ST_GATHER;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_GATHER: begin
            if (issue) begin
               if (dc_ff == D_W'(WINDOW_RADIUS)) begin
                  dc_in      = D_W'(-WINDOW_RADIUS);
                  dr_in      = dr_ff + D_W'(1);
                  row_off_in = row_off_ff + $signed(OFF_W'(w_ff));
               end else begin
                  dc_in = dc_ff + D_W'(1);
               end
            end
            if (val2_ff) begin
               acc_n_in   = acc_n_ff + N_W'(1);
               acc_sum_in = acc_sum_ff + SUM_W'(data_d_ff);
               acc_sq_in  = acc_sq_ff + SQ_W'(sq_ff);
            end
            g_cnt_in = g_cnt_ff + G_W'(1);
            if (g_cnt_ff == G_W'(WIN_SIZE + 1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            p1_in    = T_W'(acc_n_ff) * T_W'(acc_sq_ff);
            p2_in    = T_W'(acc_sum_ff) * T_W'(acc_sum_ff);
            state_in = ST_TDIFF;
         end
         ST_TDIFF: begin
            // Quotient of 4*T by the sample count feeds the root.
            div_q_in   = {p1_ff - p2_ff, 2'b00};
            div_rem_in = '0;
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            div_rem_in = rem_ge ? N_W'(rem_sh - (N_W+1)'(acc_n_ff)) : N_W'(rem_sh);
            div_q_in   = {div_q_ff[Q_W-2:0], rem_ge};
            div_cnt_in = div_cnt_ff + DC_W'(1);
            if (div_cnt_ff == DC_W'(Q_W - 1)) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (cv[S_W]) begin
               // Rounded result is floor((isqrt(q) + 1) / 2), saturated.
               if (r_wide > (S_W+1)'(DEV_MAX)) begin
                  res_in = DEV_W'(DEV_MAX);
               end else begin
                  res_in = DEV_W'(r_wide);
               end
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_dev_in   = res_ff;
               rsp_last_in  = cen_last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write) begin
         if (csr_paddr[2] == CSR_IDX_HEIGHT) begin
            height_reg_in = csr_pwdata[HEIGHT_W-1:0];
         end else begin
            width_reg_in = csr_pwdata[WIDTH_REG_W-1:0];
         end
         in_row_in   = '0;
         in_col_in   = '0;
         in_idx_in   = '0;
         in_addr_in  = '0;
         out_row_in  = '0;
         out_col_in  = '0;
         out_idx_in  = '0;
         out_addr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         width_reg_ff  <= WIDTH_RESET;
         height_reg_ff <= HEIGHT_RESET;
         in_row_ff     <= '0;
         in_col_ff     <= '0;
         in_idx_ff     <= '0;
         in_addr_ff    <= '0;
         out_row_ff    <= '0;
         out_col_ff    <= '0;
         out_idx_ff    <= '0;
         out_addr_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_val_ff     <= 1'b0;
         val2_ff       <= 1'b0;
         g_cnt_ff      <= '0;
         div_cnt_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         width_reg_ff  <= width_reg_in;
         height_reg_ff <= height_reg_in;
         in_row_ff     <= in_row_in;
         in_col_ff     <= in_col_in;
         in_idx_ff     <= in_idx_in;
         in_addr_ff    <= in_addr_in;
         out_row_ff    <= out_row_in;
         out_col_ff    <= out_col_in;
         out_idx_ff    <= out_idx_in;
         out_addr_ff   <= out_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
         rd_val_ff     <= rd_val_in;
         val2_ff       <= val2_in;
         g_cnt_ff      <= g_cnt_in;
         div_cnt_ff    <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff           <= w_in;
      h_ff           <= h_in;
      total_ff       <= total_in;
      rw_ff          <= rw_in;
      lag_ff         <= lag_in;
      item_type_ff   <= item_type_in;
      item_sample_ff <= item_sample_in;
      cen_row_ff     <= cen_row_in;
      cen_col_ff     <= cen_col_in;
      cen_addr_ff    <= cen_addr_in;
      cen_last_ff    <= cen_last_in;
      dr_ff          <= dr_in;
      dc_ff          <= dc_in;
      row_off_ff     <= row_off_in;
      data_d_ff      <= data_d_in;
      sq_ff          <= sq_in;
      acc_n_ff       <= acc_n_in;
      acc_sum_ff     <= acc_sum_in;
      acc_sq_ff      <= acc_sq_in;
      p1_ff          <= p1_in;
      p2_ff          <= p2_in;
      div_q_ff       <= div_q_in;
      div_rem_ff     <= div_rem_in;
      res_ff         <= res_in;
      rsp_dev_ff     <= rsp_dev_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // Sample history, one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[in_addr_ff] <= item_sample_ff;
      end
      rd_data_ff <= line_mem[rd_addr];
   end

   // Square root chain: each cell settles one bit and hands on to the next.
   assign cv[0]    = (state_ff == ST_ROOT);
   assign crad[0]  = (2*S_W)'(div_q_ff);
   assign crem[0]  = '0;
   assign croot[0] = '0;

   for (genvar i = 0; i < S_W; i++) begin : g_root
      if (i < S_W - 1) begin : g_mid
         llds_root_cell #(.S_W(S_W)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .valid_in  (cv[i]),
            .rad_in    (crad[i]),
            .rem_in    (crem[i]),
            .root_in   (croot[i]),
            .valid_out (cv[i+1]),
            .rad_out   (crad[i+1]),
            .rem_out   (crem[i+1]),
            .root_out  (croot[i+1])
         );
      end else begin : g_end
         llds_root_cell #(.S_W(S_W)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .valid_in  (cv[i]),
            .rad_in    (crad[i]),
            .rem_in    (crem[i]),
            .root_in   (croot[i]),
            .valid_out (cv[i+1]),
            .rad_out   (),
            .rem_out   (),
            .root_out  (croot[i+1])
         );
      end
   end

endmodule

// ----- hdl/llds_checker.sv -----
// Port-level checks for the local luma deviation unit, bound to its top level.
// Depends on llds_pkg and local_luma_deviation_5x5_unit.
module llds_checker
   import llds_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [DEV_W-1:0] rsp_deviation,
   input logic             rsp_last
);

   // A stalled result holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_deviation) && $stable(rsp_last))
      else $error("result changed while stalled");

   // The unit works on one transaction at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while busy");

   // A new result only appears at the end of the unit's busy period.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without work");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind local_luma_deviation_5x5_unit llds_checker u_llds_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_deviation (rsp_chan.deviation),
   .rsp_last      (rsp_chan.last_of_frame)
);
